@@ hw/rtl/bounded_int_list_engine_top_macros.svh @@
// Assertion macros for the list engine RTL.
`ifndef BOUNDED_INT_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_INT_LIST_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define BILE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Next-cycle implication.
`define BILE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define BILE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BILE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/bile_pkg.sv @@
// Types and codes shared by the list engine, its channels and its tests.
package bile_pkg;

    typedef logic [2:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_DELETE     = 3'd4;
    localparam t_op OP_QUERY      = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        t_op                       operation;
        logic signed [DATA_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        logic                      found;
        logic [COUNT_W-1:0]        entry_count;
        t_status                   status;
    } t_rsp;

endpackage

@@ hw/rtl/bile_if.sv @@
// Valid/ready channels for request and response words.
interface bile_req_if;
    logic          valid;
    logic          ready;
    bile_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bile_rsp_if;
    logic          valid;
    logic          ready;
    bile_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/bounded_int_list_engine_top.sv @@
// A push with room writes the RAM at accept; pop reads in S_POP; query and delete scan
//   in S_SCAN up to the first match, and a delete moves later entries down in S_SHIFT.
// Words are handled one at a time; the single RAM read port serializes scan and shift.
// Ready is high only in idle; a finished result waits in the output register.
// Reset (synchronous, active low) empties the list; RAM contents stay undefined,
//   and only entries inside the list are ever used.
`include "bounded_int_list_engine_top_macros.svh"

module bounded_int_list_engine_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bile_req_if.sink   i_req,
    bile_rsp_if.source o_rsp
);

    // Physical index width and list length width.
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    // Map a logical offset from the front onto the circular RAM.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW:0]   off);
        logic [AW+1:0] sum;
        sum = (AW+2)'(base) + (AW+2)'(off);
        if (sum >= (AW+2)'(CAPACITY)) begin
            sum = sum - (AW+2)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    // Control state.
    t_state           r_state, n_state;
    logic [AW-1:0]    r_head,  n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx,   n_idx;
    logic             r_o_valid, n_o_valid;

    // Held request and pending result.
    bile_pkg::t_op    r_op,   n_op;
    logic [31:0]      r_val,  n_val;
    bile_pkg::t_rsp   r_res,  n_res;
    bile_pkg::t_rsp   r_o_data, n_o_data;

    // RAM port.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [31:0]      ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;

    logic             acc;
    logic             is_push;
    logic             full;
    logic             empty;
    logic             out_free;
    logic             scan_last;
    logic             shift_last;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && (r_state == S_IDLE);
    assign is_push     = (i_req.data.operation == bile_pkg::OP_PUSH_FRONT) ||
                         (i_req.data.operation == bile_pkg::OP_PUSH_BACK);
    assign full        = (r_count == CW'(CAPACITY));
    assign empty       = (r_count == '0);
    assign out_free    = !r_o_valid || o_rsp.ready;
    assign scan_last   = ((CW+1)'(r_idx) + (CW+1)'(1)) == (CW+1)'(r_count);
    assign shift_last  = ((CW+1)'(r_idx) + (CW+1)'(2)) == (CW+1)'(r_count);

    bile_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_op      = r_op;
        n_val     = r_val;
        n_res     = r_res;
        n_o_data  = r_o_data;
        n_o_valid = r_o_valid && !o_rsp.ready;

        ram_we    = 1'b0;
        ram_waddr = f_phys(r_head, (CW+1)'(r_idx));
        ram_wdata = ram_rdata;
        // Scanning reads one entry ahead of the compare.
        ram_raddr = f_phys(r_head, (CW+1)'(r_idx) + (CW+1)'(1));

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_op  = i_req.data.operation;
                    n_val = i_req.data.value;
                    n_res = '0;
                    n_state = S_RESP;
                    case (i_req.data.operation)
                        bile_pkg::OP_PUSH_FRONT, bile_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                n_res.status = bile_pkg::ST_FULL;
                            end else begin
                                // Write now; the response cycle keeps the next read apart.
                                ram_we    = 1'b1;
                                ram_wdata = i_req.data.value;
                                if (i_req.data.operation == bile_pkg::OP_PUSH_FRONT) begin
                                    ram_waddr = f_phys(r_head, (CW+1)'(CAPACITY - 1));
                                    n_head    = ram_waddr;
                                end else begin
                                    ram_waddr = f_phys(r_head, (CW+1)'(r_count));
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        bile_pkg::OP_POP_FRONT, bile_pkg::OP_POP_BACK: begin
                            if (empty) begin
                                n_res.status = bile_pkg::ST_EMPTY;
                            end else begin
                                if (i_req.data.operation == bile_pkg::OP_POP_FRONT) begin
                                    ram_raddr = r_head;
                                end else begin
                                    ram_raddr = f_phys(r_head,
                                                       (CW+1)'(r_count) - (CW+1)'(1));
                                end
                                n_state = S_POP;
                            end
                        end
                        bile_pkg::OP_DELETE, bile_pkg::OP_QUERY: begin
                            if (!empty) begin
                                ram_raddr = r_head;
                                n_idx     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_POP: begin
                n_res.popped_value = ram_rdata;
                n_count = r_count - CW'(1);
                if (r_op == bile_pkg::OP_POP_FRONT) begin
                    n_head = f_phys(r_head, (CW+1)'(1));
                end
                n_state = S_RESP;
            end

            S_SCAN: begin
                if (ram_rdata == r_val) begin
                    n_res.found = 1'b1;
                    if (r_op == bile_pkg::OP_DELETE) begin
                        if (scan_last) begin
                            n_count = r_count - CW'(1);
                            n_state = S_RESP;
                        end else begin
                            // Close the gap: entry idx+1 is already on its way.
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_state = S_RESP;
                    end
                end else if (scan_last) begin
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end

            S_SHIFT: begin
                // Move entry idx+1 down to idx and fetch idx+2.
                ram_we    = 1'b1;
                ram_raddr = f_phys(r_head, (CW+1)'(r_idx) + (CW+1)'(2));
                if (shift_last) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end

            S_RESP: begin
                // Hold here until the output register frees up.
                if (out_free) begin
                    n_o_valid            = 1'b1;
                    n_o_data             = r_res;
                    n_o_data.entry_count = bile_pkg::COUNT_W'(r_count);
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_o_valid <= n_o_valid;
        end
        r_op     <= n_op;
        r_val    <= n_val;
        r_res    <= n_res;
        r_o_data <= n_o_data;
    end

    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o_data;

    // The list never grows past its capacity.
    `BILE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    // An accepted push with room grows the list by exactly one word.
    `BILE_ASSERT_NXT(a_push_grow, i_clk, i_rst_n, acc && is_push && !full, r_count == $past(r_count) + CW'(1))
    // The shift only moves entries that lie inside the list.
    `BILE_ASSERT_IMP(a_shift_range, i_clk, i_rst_n, r_state == S_SHIFT, (CW+1)'(r_idx) + (CW+1)'(2) <= (CW+1)'(r_count))
    // A stalled output keeps the finished result waiting.
    `BILE_ASSERT_NXT(a_resp_hold, i_clk, i_rst_n, (r_state == S_RESP) && r_o_valid && !o_rsp.ready, r_state == S_RESP)

endmodule

@@ hw/rtl/bile_ram.sv @@
// Generic one-write, one-read RAM with registered read data.
module bile_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/sv/bounded_int_list_engine_top_tb.sv @@
// Self-checking testbench for the bounded integer list engine: table-driven and random requests.
module bounded_int_list_engine_top_tb;

    // Keep the list size in step with the block's default.
    localparam int unsigned LIST_CAP    = 16;
    // Far above the slowest legal run: ~1100 words, each with a full sender gap,
    // a worst-case scan and shift, a full receiver stall, plus two long hold-offs.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RAND_WORDS  = 1050;
    localparam int unsigned DRAIN_WAIT  = 40;
    // Receiver hold-off, long enough to back the block up into its input.
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 10;

    // Codes the block treats as no-ops.
    localparam bile_pkg::t_op OP_SPARE_6 = 3'd6;
    localparam bile_pkg::t_op OP_SPARE_7 = 3'd7;

    logic i_clk;
    logic i_rst_n;

    bile_req_if req_ch ();
    bile_rsp_if rsp_ch ();

    bounded_int_list_engine_top #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // One row of the directed table. Rows with typed set carry a response that
    // can be read straight off the list contents; the rest go to the predictor.
    typedef struct {
        bile_pkg::t_op  op;
        logic [31:0]    value;
        int unsigned    reps;
        bit             typed;
        bile_pkg::t_rsp rsp;
    } t_dir_row;

    // Tag that travels with each word from the driver to the monitor.
    typedef struct {
        bit             typed;
        bile_pkg::t_rsp rsp;
    } t_word_tag;

    // Walk: empty-list errors and no-ops, extremes pushed at both ends, fill to
    // full, push on full at both ends, pops of the extremes, then delete of a
    // duplicated value, delete of an absent value, a hit query and a spare code.
    t_dir_row dir_rows [0:15] = '{
        '{bile_pkg::OP_POP_FRONT,  32'h0000_0000, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd0,  bile_pkg::ST_EMPTY}},
        '{bile_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd0,  bile_pkg::ST_EMPTY}},
        '{bile_pkg::OP_DELETE,     32'h0000_0000, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd0,  bile_pkg::ST_OK}},
        '{bile_pkg::OP_QUERY,      32'h8000_0000, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd0,  bile_pkg::ST_OK}},
        '{OP_SPARE_6,              32'h7FFF_FFFF, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd0,  bile_pkg::ST_OK}},
        '{bile_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd1,  bile_pkg::ST_OK}},
        '{bile_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd2,  bile_pkg::ST_OK}},
        '{bile_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 14, 1'b0, '0},
        '{bile_pkg::OP_PUSH_FRONT, 32'h0000_0001, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd16, bile_pkg::ST_FULL}},
        '{bile_pkg::OP_PUSH_BACK,  32'h0000_0001, 1,  1'b1,
          {32'h0000_0000, 1'b0, 5'd16, bile_pkg::ST_FULL}},
        '{bile_pkg::OP_POP_FRONT,  32'h0000_0000, 1,  1'b1,
          {32'h8000_0000, 1'b0, 5'd15, bile_pkg::ST_OK}},
        '{bile_pkg::OP_POP_BACK,   32'h0000_0000, 1,  1'b1,
          {32'hFFFF_FFFF, 1'b0, 5'd14, bile_pkg::ST_OK}},
        '{bile_pkg::OP_DELETE,     32'hFFFF_FFFF, 1,  1'b0, '0},
        '{bile_pkg::OP_DELETE,     32'h0000_0000, 1,  1'b0, '0},
        '{bile_pkg::OP_QUERY,      32'h7FFF_FFFF, 1,  1'b0, '0},
        '{OP_SPARE_7,              32'h0000_0000, 1,  1'b0, '0}
    };

    // Predictor state: list contents front first, and the entry count.
    logic [31:0] list_words [0:LIST_CAP-1];
    int unsigned list_len;

    t_word_tag      word_tags [$];
    bile_pkg::t_rsp predicted_rsps [$];
    int unsigned    fail_count;
    int unsigned    cycle_count;

    // Apply one request to the predictor's list and return its response.
    function automatic bile_pkg::t_rsp predict_list_result(input bile_pkg::t_op op,
                                                           input logic [31:0] v);
        bile_pkg::t_rsp r;
        int             hit;
        int unsigned    i;
        r   = '0;
        hit = -1;
        case (op)
            bile_pkg::OP_PUSH_FRONT, bile_pkg::OP_PUSH_BACK: begin
                if (list_len >= LIST_CAP) begin
                    r.status = bile_pkg::ST_FULL;
                end else if (op == bile_pkg::OP_PUSH_FRONT) begin
                    for (i = list_len; i > 0; i--)
                        list_words[i] = list_words[i-1];
                    list_words[0] = v;
                    list_len++;
                end else begin
                    list_words[list_len] = v;
                    list_len++;
                end
            end
            bile_pkg::OP_POP_FRONT, bile_pkg::OP_POP_BACK: begin
                if (list_len == 0) begin
                    r.status = bile_pkg::ST_EMPTY;
                end else if (op == bile_pkg::OP_POP_FRONT) begin
                    r.popped_value = list_words[0];
                    for (i = 0; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end else begin
                    r.popped_value = list_words[list_len-1];
                    list_len--;
                end
            end
            bile_pkg::OP_DELETE, bile_pkg::OP_QUERY: begin
                // Match on the frontmost equal entry only.
                for (i = 0; i < list_len && hit < 0; i++)
                    if (list_words[i] == v)
                        hit = i;
                if (hit >= 0) begin
                    r.found = 1'b1;
                    if (op == bile_pkg::OP_DELETE) begin
                        for (i = hit; i + 1 < list_len; i++)
                            list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = bile_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    // Draw a value: often one already in the list so deletes and queries hit,
    // often a small value so duplicates pile up, plus extremes and full noise.
    function automatic logic [31:0] pick_value();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 4 && list_len != 0)
            return list_words[$urandom_range(0, list_len - 1)];
        if (k == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (k < 7)
            return $urandom_range(0, 7);
        return $urandom;
    endfunction

    // Offer one request word after a random gap, and hold it until accepted.
    // The gap is skipped entirely in calm stretches, so words go back to back.
    task automatic send_word(input bile_pkg::t_op op, input logic [31:0] v, input bit typed,
                             input bile_pkg::t_rsp rsp, input bit calm);
        int unsigned gap;
        t_word_tag   tag;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tag.typed = typed;
        tag.rsp   = rsp;
        word_tags.push_back(tag);
        req_ch.valid <= 1'b1;
        req_ch.data  <= {op, v};
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Monitor both channels at the rising edge: advance the predictor on each
    // accepted request, and check each accepted response against the oldest one due.
    always @(posedge i_clk) begin : watch
        t_word_tag      tag;
        bile_pkg::t_rsp pred;
        bile_pkg::t_rsp due;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                tag  = word_tags.pop_front();
                pred = predict_list_result(req_ch.data.operation, req_ch.data.value);
                predicted_rsps.push_back(tag.typed ? tag.rsp : pred);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (predicted_rsps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected response word: popped %h found %b count %0d status %0d",
                                 rsp_ch.data.popped_value, rsp_ch.data.found,
                                 rsp_ch.data.entry_count, rsp_ch.data.status);
                end else begin
                    due = predicted_rsps.pop_front();
                    if (rsp_ch.data.popped_value !== due.popped_value ||
                        rsp_ch.data.found !== due.found ||
                        rsp_ch.data.entry_count !== due.entry_count ||
                        rsp_ch.data.status !== due.status) begin
                        fail_count++;
                        // Fields in order: popped value, found, count, status.
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch at cycle %0d: got %h/%b/%0d/%0d, expected %h/%b/%0d/%0d",
                                     cycle_count, rsp_ch.data.popped_value, rsp_ch.data.found,
                                     rsp_ch.data.entry_count, rsp_ch.data.status,
                                     due.popped_value, due.found, due.entry_count, due.status);
                    end
                end
            end
        end
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Response side: stall a random number of cycles per word, with calm
    // stretches of none, and twice hold off for a long stretch so the block
    // backs up and drops ready on its input.
    initial begin : rsp_sink
        int unsigned stall;
        int unsigned taken;
        bit          calm;
        taken = 0;
        calm  = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 14);
            if (taken == 250 || taken == 700)
                stall = HOLD_CYCLES;
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned   sent;
        int unsigned   seg_len;
        int unsigned   push_pct;
        int unsigned   r;
        int unsigned   n;
        bit            calm;
        bile_pkg::t_op op;

        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        list_len     = 0;

        // Hold reset, then release it between edges.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[row])
            for (n = 0; n < dir_rows[row].reps; n++)
                send_word(dir_rows[row].op, dir_rows[row].value, dir_rows[row].typed,
                          dir_rows[row].rsp, 1'b0);

        // Random segments, each leaning toward filling, draining or neither,
        // so the list keeps swinging between empty and full.
        sent = 0;
        while (sent < RAND_WORDS) begin
            seg_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 70;
                1:       push_pct = 15;
                default: push_pct = 40;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (n = 0; n < seg_len && sent < RAND_WORDS; n++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    op = r[0] ? bile_pkg::OP_PUSH_FRONT : bile_pkg::OP_PUSH_BACK;
                end else if (r < 85) begin
                    case ($urandom_range(0, 3))
                        0:       op = bile_pkg::OP_POP_FRONT;
                        1:       op = bile_pkg::OP_POP_BACK;
                        2:       op = bile_pkg::OP_DELETE;
                        default: op = bile_pkg::OP_QUERY;
                    endcase
                end else if (r < 97) begin
                    op = r[0] ? bile_pkg::OP_DELETE : bile_pkg::OP_QUERY;
                end else begin
                    op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
                end
                send_word(op, pick_value(), 1'b0, '0, calm);
                sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain: wait for every response due, then let the pipeline settle.
        while (word_tags.size() != 0 || predicted_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (predicted_rsps.size() != 0) begin
            fail_count++;
            $display("%0d response words never arrived", predicted_rsps.size());
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bile_pkg.sv
hw/rtl/bile_if.sv
hw/rtl/bile_ram.sv
hw/rtl/bounded_int_list_engine_top.sv
tb/sv/bounded_int_list_engine_top_tb.sv
